@@ rtl/kcl_pkg.sv @@
// Shared types, constants and helpers for the keypad code lock.
// No dependencies; kcl_in_if, kcl_scan and keypad_code_lock_core refer to this package by scope.
`default_nettype none

package kcl_pkg;

  // Key matrix geometry defaults and the fixed width of the raw key field
  localparam int KEY_ROWS_DEF = 4;
  localparam int KEY_COLS_DEF = 4;
  localparam int RAW_W        = 16;
  localparam int IDX_W        = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_CYC   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT     = 3'd6;

  // Register reset values
  localparam logic [7:0]  CODE_FIRST_RST  = 8'h30;   // '0'
  localparam logic [7:0]  CODE_SECOND_RST = 8'h39;   // '9'
  localparam logic [7:0]  DEBOUNCE_RST    = 8'd20;
  localparam logic [15:0] OPEN_RST        = 16'd3000;
  localparam logic [15:0] BLINK_HALF_RST  = 16'd500;
  localparam logic [3:0]  BLINK_CYC_RST   = 4'd6;
  localparam logic [15:0] LOCKOUT_RST     = 16'd5000;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_OPEN  = 2'd1;
  localparam logic [1:0] VERDICT_WRONG = 2'd2;

  // Phase codes as reported on the result channel
  localparam logic [2:0] PHASE_CODE_WAIT    = 3'd0;
  localparam logic [2:0] PHASE_CODE_RELEASE = 3'd1;
  localparam logic [2:0] PHASE_CODE_OPEN    = 3'd2;
  localparam logic [2:0] PHASE_CODE_BLINK   = 3'd3;
  localparam logic [2:0] PHASE_CODE_LOCK    = 3'd4;

  typedef enum logic [4:0] {
    PH_WAIT    = 5'b00001,
    PH_RELEASE = 5'b00010,
    PH_OPEN    = 5'b00100,
    PH_BLINK   = 5'b01000,
    PH_LOCK    = 5'b10000
  } phase_t;

  // Result of one scan of the key matrix
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [7:0]       ch;
  } scan_t;

  // Character legend of the 4x4 pad, row-major
  localparam logic [7:0] CHAR_MAP [4][4] = '{
    '{8'h2A, 8'h30, 8'h23, 8'h44},   // * 0 # D
    '{8'h37, 8'h38, 8'h39, 8'h43},   // 7 8 9 C
    '{8'h34, 8'h35, 8'h36, 8'h42},   // 4 5 6 B
    '{8'h31, 8'h32, 8'h33, 8'h41}    // 1 2 3 A
  };

  function automatic logic [7:0] char_at(input int row, input int col);
    logic [1:0] r2;
    logic [1:0] c2;
    r2 = row[1:0];
    c2 = col[1:0];
    if (row < 4 && col < 4) begin
      return CHAR_MAP[r2][c2];
    end
    return 8'h00;
  endfunction

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_WAIT:    code = PHASE_CODE_WAIT;
      PH_RELEASE: code = PHASE_CODE_RELEASE;
      PH_OPEN:    code = PHASE_CODE_OPEN;
      PH_BLINK:   code = PHASE_CODE_BLINK;
      PH_LOCK:    code = PHASE_CODE_LOCK;
      default:    code = PHASE_CODE_WAIT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ rtl/kcl_in_if.sv @@
// Input channel of the keypad code lock: one raw key matrix per beat.
// Depends on kcl_pkg for the field width.
`default_nettype none

interface kcl_in_if;
  logic                     valid;
  logic                     ready;
  logic [kcl_pkg::RAW_W-1:0] raw_keys;

  modport source (output valid, output raw_keys, input ready);
  modport sink   (input valid, input raw_keys, output ready);
endinterface

`default_nettype wire

@@ rtl/kcl_out_if.sv @@
// Result channel of the keypad code lock: one result beat per input beat.
// Standalone; the widths are the fixed field widths.
`default_nettype none

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic       key_valid;
  logic [7:0] key_char;
  logic [1:0] verdict;
  logic       leds_on;
  logic       clear_display;
  logic [2:0] phase;

  modport source (output valid, output key_valid, output key_char, output verdict,
                  output leds_on, output clear_display, output phase, input ready);
  modport sink   (input valid, input key_valid, input key_char, input verdict,
                  input leds_on, input clear_display, input phase, output ready);
endinterface

`default_nettype wire

@@ rtl/kcl_scan.sv @@
// Key matrix scanner: priority pick of the pressed key and its character.
// Depends on kcl_pkg (scan_t, char_at).
`default_nettype none

module kcl_scan #(
  parameter int KEY_ROWS = kcl_pkg::KEY_ROWS_DEF,
  parameter int KEY_COLS = kcl_pkg::KEY_COLS_DEF
) (
  input  wire logic [kcl_pkg::RAW_W-1:0] raw_keys,
  output kcl_pkg::scan_t                 scan
);

  localparam int NKEYS = (KEY_ROWS * KEY_COLS < kcl_pkg::RAW_W) ?
                         KEY_ROWS * KEY_COLS : kcl_pkg::RAW_W;

  logic [7:0]              char_lut [kcl_pkg::RAW_W];
  logic                    hit;
  logic [kcl_pkg::IDX_W-1:0] idx;

  // Legend per bit position; keys past the pad edge have no character
  always_comb begin
    for (int i = 0; i < kcl_pkg::RAW_W; i++) begin
      if (i < NKEYS) begin
        char_lut[i] = kcl_pkg::char_at(i / KEY_COLS, i % KEY_COLS);
      end else begin
        char_lut[i] = 8'h00;
      end
    end
  end

  // Lowest row first, then lowest column: the lowest existing set bit wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = NKEYS - 1; i >= 0; i--) begin
      if (raw_keys[i]) begin
        hit = 1'b1;
        idx = kcl_pkg::IDX_W'(i);
      end
    end
  end

  assign scan.hit = hit;
  assign scan.idx = idx;
  assign scan.ch  = hit ? char_lut[idx] : 8'h00;

endmodule

`default_nettype wire

@@ rtl/keypad_code_lock_core.sv @@
// Top level of the keypad code lock: config registers, lock sequencer, beat registers.
// Depends on kcl_pkg, kcl_in_if, kcl_out_if and kcl_scan.
//
// Usage
//   in_ch  : one beat per millisecond tick, carrying the raw key matrix (bit row*cols+col).
//   out_ch : exactly one result beat per input beat, in order: accepted key and its
//            ASCII character, verdict, LED drive, display-clear strobe and phase.
//   cfg_*  : write-only register port, taken on any edge with cfg_we high; write it
//            only while no beat is in flight.
// Timing
//   An input beat is held in an input register, the lock sequencer steps once on it
//   and the result lands in the output register. One beat per cycle is sustained while
//   out_ch is not stalled; the rate is set by the combinational sequencer step between
//   the two registers.
// Stalls
//   While out_ch is stalled the output register holds its beat, the input register
//   may still take one beat, and in_ch.ready drops only once both are full.
// Reset
//   rst_n (synchronous, active low) empties both beat registers, restores the register
//   defaults (code "09", 20-tick sampling, 3000 open, 500 blink half, 6 blinks,
//   5000 lockout) and puts the sequencer in wait-for-key with no digit held.
`default_nettype none

module keypad_code_lock_core #(
  parameter int KEY_ROWS = kcl_pkg::KEY_ROWS_DEF,
  parameter int KEY_COLS = kcl_pkg::KEY_COLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  kcl_in_if.sink                             in_ch,
  kcl_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------- config registers
  logic [7:0]  code_first_r, code_second_r, debounce_r;
  logic [15:0] open_r, blink_half_r, lockout_r;
  logic [3:0]  blink_cyc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_first_r  <= kcl_pkg::CODE_FIRST_RST;
      code_second_r <= kcl_pkg::CODE_SECOND_RST;
      debounce_r    <= kcl_pkg::DEBOUNCE_RST;
      open_r        <= kcl_pkg::OPEN_RST;
      blink_half_r  <= kcl_pkg::BLINK_HALF_RST;
      blink_cyc_r   <= kcl_pkg::BLINK_CYC_RST;
      lockout_r     <= kcl_pkg::LOCKOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcl_pkg::CFG_CODE_FIRST:  code_first_r  <= cfg_wdata[7:0];
        kcl_pkg::CFG_CODE_SECOND: code_second_r <= cfg_wdata[7:0];
        kcl_pkg::CFG_DEBOUNCE:    debounce_r    <= cfg_wdata[7:0];
        kcl_pkg::CFG_OPEN:        open_r        <= cfg_wdata;
        kcl_pkg::CFG_BLINK_HALF:  blink_half_r  <= cfg_wdata;
        kcl_pkg::CFG_BLINK_CYC:   blink_cyc_r   <= cfg_wdata[3:0];
        kcl_pkg::CFG_LOCKOUT:     lockout_r     <= cfg_wdata;
        default: ;                // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------- beat registers
  logic                      in_valid_r;
  logic [kcl_pkg::RAW_W-1:0] in_keys_r;
  logic                      out_valid_r;
  logic                      advance;

  // Step the sequencer whenever a held input beat can move into the output register
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_keys_r <= in_ch.raw_keys;
    end
  end

  // ---------------------------------------------------------------- key scan
  kcl_pkg::scan_t scan;

  kcl_scan #(
    .KEY_ROWS (KEY_ROWS),
    .KEY_COLS (KEY_COLS)
  ) u_scan (
    .raw_keys (in_keys_r),
    .scan     (scan)
  );

  // ---------------------------------------------------------------- lock sequencer
  kcl_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] period_r, period_nxt;
  logic [7:0]  sample_tmr_r, sample_tmr_nxt;
  logic [4:0]  last_r, last_nxt;               // {valid, key index}
  logic [7:0]  first_digit_r, first_digit_nxt;
  logic        digit_cnt_r, digit_cnt_nxt;
  logic [3:0]  blink_cnt_r, blink_cnt_nxt;
  logic [7:0]  held_key_r, held_key_nxt;
  logic        lit_r, lit_nxt;

  logic        kv;
  logic [7:0]  kc;
  logic [1:0]  verdict;
  logic        clr;
  logic        leds;

  logic [7:0]  deb_period;
  logic [15:0] open_load, half_load;
  logic [3:0]  blink_load;
  logic        sample_due;
  logic [4:0]  scan_code;

  assign deb_period = (debounce_r == 8'd0) ? 8'd1 : debounce_r;
  assign open_load  = (open_r == 16'd0) ? 16'd1 : open_r;
  assign half_load  = (blink_half_r == 16'd0) ? 16'd1 : blink_half_r;
  assign blink_load = (blink_cyc_r == 4'd0) ? 4'd1 : blink_cyc_r;
  assign sample_due = ({1'b0, sample_tmr_r} + 9'd1) >= {1'b0, deb_period};
  assign scan_code  = {scan.hit, scan.idx};

  always_comb begin
    phase_nxt       = phase_r;
    period_nxt      = period_r;
    sample_tmr_nxt  = sample_tmr_r;
    last_nxt        = last_r;
    first_digit_nxt = first_digit_r;
    digit_cnt_nxt   = digit_cnt_r;
    blink_cnt_nxt   = blink_cnt_r;
    held_key_nxt    = held_key_r;
    lit_nxt         = lit_r;
    kv              = 1'b0;
    kc              = 8'h00;
    verdict         = kcl_pkg::VERDICT_NONE;
    clr             = 1'b0;

    unique case (phase_r)
      kcl_pkg::PH_WAIT: begin
        if (sample_due) begin
          sample_tmr_nxt = 8'd0;
          // Accept on two agreeing samples of a key that has a character
          if (scan.hit && scan_code == last_r && scan.ch != 8'h00) begin
            kv           = 1'b1;
            kc           = scan.ch;
            held_key_nxt = scan.ch;
            clr          = !digit_cnt_r;
            phase_nxt    = kcl_pkg::PH_RELEASE;
          end else begin
            last_nxt = scan_code;
          end
        end else begin
          sample_tmr_nxt = sample_tmr_r + 8'd1;
        end
      end

      kcl_pkg::PH_RELEASE: begin
        if (sample_due) begin
          sample_tmr_nxt = 8'd0;
          if (scan.ch == 8'h00) begin
            last_nxt = 5'd0;
            if (!digit_cnt_r) begin
              first_digit_nxt = held_key_r;
              digit_cnt_nxt   = 1'b1;
              phase_nxt       = kcl_pkg::PH_WAIT;
            end else begin
              digit_cnt_nxt = 1'b0;
              if (first_digit_r == code_first_r && held_key_r == code_second_r) begin
                verdict    = kcl_pkg::VERDICT_OPEN;
                phase_nxt  = kcl_pkg::PH_OPEN;
                period_nxt = open_load;
              end else begin
                verdict       = kcl_pkg::VERDICT_WRONG;
                phase_nxt     = kcl_pkg::PH_BLINK;
                lit_nxt       = 1'b1;
                blink_cnt_nxt = blink_load;
                period_nxt    = half_load;
              end
            end
          end
        end else begin
          sample_tmr_nxt = sample_tmr_r + 8'd1;
        end
      end

      kcl_pkg::PH_OPEN: begin
        if (period_r <= 16'd1) begin
          // Enter lockout, or skip straight to waiting when it is zero
          sample_tmr_nxt = 8'd0;
          last_nxt       = 5'd0;
          if (lockout_r == 16'd0) begin
            phase_nxt = kcl_pkg::PH_WAIT;
            clr       = 1'b1;
          end else begin
            phase_nxt  = kcl_pkg::PH_LOCK;
            period_nxt = lockout_r;
          end
        end else begin
          period_nxt = period_r - 16'd1;
        end
      end

      kcl_pkg::PH_BLINK: begin
        if (period_r <= 16'd1) begin
          if (lit_r) begin
            lit_nxt    = 1'b0;
            period_nxt = half_load;
          end else begin
            blink_cnt_nxt = blink_cnt_r - 4'd1;
            if (blink_cnt_nxt == 4'd0) begin
              sample_tmr_nxt = 8'd0;
              last_nxt       = 5'd0;
              if (lockout_r == 16'd0) begin
                phase_nxt = kcl_pkg::PH_WAIT;
                clr       = 1'b1;
              end else begin
                phase_nxt  = kcl_pkg::PH_LOCK;
                period_nxt = lockout_r;
              end
            end else begin
              lit_nxt    = 1'b1;
              period_nxt = half_load;
            end
          end
        end else begin
          period_nxt = period_r - 16'd1;
        end
      end

      kcl_pkg::PH_LOCK: begin
        if (period_r <= 16'd1) begin
          phase_nxt      = kcl_pkg::PH_WAIT;
          clr            = 1'b1;
          sample_tmr_nxt = 8'd0;
          last_nxt       = 5'd0;
        end else begin
          period_nxt = period_r - 16'd1;
        end
      end

      default: begin
        phase_nxt      = kcl_pkg::PH_WAIT;
        sample_tmr_nxt = 8'd0;
        last_nxt       = 5'd0;
      end
    endcase

    leds = (phase_nxt == kcl_pkg::PH_OPEN) || (phase_nxt == kcl_pkg::PH_BLINK && lit_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= kcl_pkg::PH_WAIT;
      period_r      <= 16'd0;
      sample_tmr_r  <= 8'd0;
      last_r        <= 5'd0;
      first_digit_r <= 8'd0;
      digit_cnt_r   <= 1'b0;
      blink_cnt_r   <= 4'd0;
      held_key_r    <= 8'd0;
      lit_r         <= 1'b0;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      period_r      <= period_nxt;
      sample_tmr_r  <= sample_tmr_nxt;
      last_r        <= last_nxt;
      first_digit_r <= first_digit_nxt;
      digit_cnt_r   <= digit_cnt_nxt;
      blink_cnt_r   <= blink_cnt_nxt;
      held_key_r    <= held_key_nxt;
      lit_r         <= lit_nxt;
    end
  end

  // ---------------------------------------------------------------- result register
  logic       key_valid_r, leds_r, clr_r;
  logic [7:0] key_char_r;
  logic [1:0] verdict_r;
  logic [2:0] phase_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_valid_r <= kv;
      key_char_r  <= kc;
      verdict_r   <= verdict;
      leds_r      <= leds;
      clr_r       <= clr;
      phase_out_r <= kcl_pkg::phase_code(phase_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.key_valid     = key_valid_r;
  assign out_ch.key_char      = key_char_r;
  assign out_ch.verdict       = verdict_r;
  assign out_ch.leds_on       = leds_r;
  assign out_ch.clear_display = clr_r;
  assign out_ch.phase         = phase_out_r;

`ifndef SYNTHESIS
  // A verdict is only ever reported together with the phase it leads into
  a_verdict_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && verdict_r == kcl_pkg::VERDICT_OPEN) |->
      (phase_out_r == kcl_pkg::PHASE_CODE_OPEN))
    else $error("open verdict without open phase");

  a_wrong_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && verdict_r == kcl_pkg::VERDICT_WRONG) |->
      (phase_out_r == kcl_pkg::PHASE_CODE_BLINK && leds_r))
    else $error("wrong verdict without lit blink phase");

  // An accepted key always moves the lock to waiting for release
  a_key_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && key_valid_r) |->
      (phase_out_r == kcl_pkg::PHASE_CODE_RELEASE && key_char_r != 8'h00))
    else $error("accepted key without release phase");

  // The sequencer must not step while its beat cannot be delivered
  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> ($stable(phase_r) && $stable(period_r)))
    else $error("sequencer stepped during a stall");
`endif

endmodule

`default_nettype wire
